// ----- rtl/core/register_dependency_profiler_unit_assert.svh -----
// Assertion macros used by the checker in rdp_chk.sv.
`ifndef REGISTER_DEPENDENCY_PROFILER_UNIT_ASSERT_SVH
`define REGISTER_DEPENDENCY_PROFILER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RDP_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rdp assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RDP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rdp assertion failed");

`endif

// ----- rtl/core/rdp_pkg.sv -----
package rdp_pkg;

  localparam int DEF_NUM_REGS   = 512;
  localparam int DEF_AGE_BINS   = 128;
  localparam int DEF_USE_BINS   = 128;
  localparam int DEF_OPER_BINS  = 16;
  localparam int DEF_COUNT_BITS = 48;

  localparam int KIND_W      = 3;
  localparam int REG_ID_W    = 9;
  localparam int INS_COUNT_W = 48;
  localparam int OP_COUNT_W  = 4;
  localparam int TABLE_SEL_W = 2;
  localparam int BIN_IDX_W   = 7;
  localparam int BIN_VALUE_W = 48;

  localparam logic [KIND_W-1:0] KIND_REG_RD  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REG_WR  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INS_END = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BIN_RD  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd4;

  localparam logic [TABLE_SEL_W-1:0] TBL_AGE  = 2'd0;
  localparam logic [TABLE_SEL_W-1:0] TBL_USE  = 2'd1;
  localparam logic [TABLE_SEL_W-1:0] TBL_OPER = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [REG_ID_W-1:0]    reg_id;
    logic [INS_COUNT_W-1:0] ins_count;
    logic [OP_COUNT_W-1:0]  op_count;
    logic [TABLE_SEL_W-1:0] table_select;
    logic [BIN_IDX_W-1:0]   bin_index;
  } in_item_t;

  typedef struct packed {
    logic [BIN_VALUE_W-1:0] bin_value;
    logic [BIN_IDX_W-1:0]   bin_echo;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK,
    ST_UPD,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic accept;
    logic look;
    logic upd;
    logic out_load;
    logic sweep;
    logic sweep_regs;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic out_blocked;
    logic item_bin_rd;
  } dp_sts_t;

endpackage

// ----- rtl/core/rdp_ctrl.sv -----
module rdp_ctrl
  import rdp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [KIND_W-1:0] in_kind,
  output logic              in_stall,
  input  dp_sts_t           sts,
  output dp_cmd_t           cmd
);

  state_t state_r, state_nxt;
  logic   take_ok;
  logic   accept;

  function automatic state_t after_accept(input logic [KIND_W-1:0] kind);
    state_t st;
    case (kind)
      KIND_REG_RD, KIND_REG_WR, KIND_INS_END, KIND_BIN_RD: st = ST_LOOK;
      KIND_CLEAR: st = ST_CLEAR;
      default: st = ST_IDLE;
    endcase
    return st;
  endfunction

  // A readout waits in ST_UPD until the output register can take it.
  assign take_ok = (state_r == ST_IDLE) ||
                   ((state_r == ST_UPD) && !(sts.item_bin_rd && sts.out_blocked));
  assign accept  = in_valid && take_ok;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (sts.sweep_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_nxt = after_accept(in_kind);
      end
      ST_LOOK: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (accept) begin
          state_nxt = after_accept(in_kind);
        end else if (take_ok) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (sts.sweep_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_stall   = !take_ok;
    cmd.accept = accept;
    case (state_r)
      ST_INIT: begin
        cmd.sweep      = 1'b1;
        cmd.sweep_regs = 1'b1;
      end
      ST_LOOK: begin
        cmd.look = 1'b1;
      end
      ST_UPD: begin
        cmd.upd      = take_ok;
        cmd.out_load = take_ok && sts.item_bin_rd;
      end
      ST_CLEAR: begin
        cmd.sweep = 1'b1;
      end
      default: begin
        cmd.sweep = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/rdp_dp.sv -----
module rdp_dp
  import rdp_pkg::*;
#(
  parameter int NUM_REGS   = DEF_NUM_REGS,
  parameter int AGE_BINS   = DEF_AGE_BINS,
  parameter int USE_BINS   = DEF_USE_BINS,
  parameter int OPER_BINS  = DEF_OPER_BINS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_payload,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_payload
);

  localparam int RAW = $clog2(NUM_REGS);
  localparam int AAW = $clog2(AGE_BINS);
  localparam int UAW = $clog2(USE_BINS);
  localparam int OAW = $clog2(OPER_BINS);
  localparam int HIST_DEPTH0 = (AGE_BINS > USE_BINS) ? AGE_BINS : USE_BINS;
  localparam int HIST_DEPTH  = (HIST_DEPTH0 > OPER_BINS) ? HIST_DEPTH0 : OPER_BINS;
  localparam int ALL_DEPTH   = (NUM_REGS > HIST_DEPTH) ? NUM_REGS : HIST_DEPTH;
  localparam int HAW = $clog2(HIST_DEPTH);
  localparam int SW  = $clog2(ALL_DEPTH) + 1;
  localparam int RIW = ((REG_ID_W > RAW) ? REG_ID_W : RAW) + 1;
  localparam int BIW = ((BIN_IDX_W > HAW) ? BIN_IDX_W : HAW) + 1;
  localparam int OPW = ((OP_COUNT_W > OAW) ? OP_COUNT_W : OAW) + 1;

  // per-register table
  logic [COUNT_BITS-1:0] lwc_mem [NUM_REGS];
  logic [UAW-1:0]        use_mem [NUM_REGS];
  logic                  ref_mem [NUM_REGS];
  // histograms
  logic [COUNT_BITS-1:0] age_mem  [AGE_BINS];
  logic [COUNT_BITS-1:0] usdg_mem [USE_BINS];
  logic [COUNT_BITS-1:0] oper_mem [OPER_BINS];

  in_item_t              item_r;
  logic [COUNT_BITS-1:0] lwc_rd_r;
  logic [UAW-1:0]        use_rd_r;
  logic                  ref_rd_r;
  logic [COUNT_BITS-1:0] age_rd_r, usdg_rd_r, oper_rd_r;
  logic [AAW-1:0]        age_addr_r;
  logic [UAW-1:0]        usdg_addr_r;
  logic [OAW-1:0]        oper_addr_r;
  logic                  bump_age_r, bump_use_r, bump_oper_r, rd_hit_r;
  logic [SW-1:0]         sw_cnt_r, sw_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r;

  logic [RAW-1:0]        rt_raddr, rt_waddr;
  logic                  rt_we;
  logic [COUNT_BITS-1:0] lwc_wdata;
  logic [UAW-1:0]        use_wdata;
  logic                  ref_wdata;
  logic                  reg_ok, is_rd, is_wr, is_ins, is_bin;
  logic [COUNT_BITS-1:0] now_c, age;
  logic [AAW-1:0]        age_bin, age_raddr;
  logic [UAW-1:0]        usdg_raddr;
  logic [OPW-1:0]        opx;
  logic [OAW-1:0]        oper_bin, oper_raddr;
  logic [BIW-1:0]        bix;
  logic                  rd_hit;
  logic                  age_we, usdg_we, oper_we;
  logic [AAW-1:0]        age_waddr;
  logic [UAW-1:0]        usdg_waddr;
  logic [OAW-1:0]        oper_waddr;
  logic [COUNT_BITS-1:0] age_wdata, usdg_wdata, oper_wdata, rd_sel;
  logic                  sweep_last;

  assign is_rd  = (item_r.kind == KIND_REG_RD);
  assign is_wr  = (item_r.kind == KIND_REG_WR);
  assign is_ins = (item_r.kind == KIND_INS_END);
  assign is_bin = (item_r.kind == KIND_BIN_RD);
  assign reg_ok = RIW'(item_r.reg_id) < RIW'(NUM_REGS);
  assign now_c  = COUNT_BITS'(item_r.ins_count);

  // ---------------- sweep counter ----------------
  assign sweep_last = (sw_cnt_r == (cmd.sweep_regs ? SW'(ALL_DEPTH - 1) : SW'(HIST_DEPTH - 1)));
  assign sw_cnt_nxt = sweep_last ? '0 : sw_cnt_r + SW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_cnt_r <= '0;
    end else if (cmd.sweep) begin
      sw_cnt_r <= sw_cnt_nxt;
    end
  end

  // ---------------- item register and per-register table ----------------
  assign rt_raddr = RAW'(in_payload.reg_id);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r   <= in_payload;
      lwc_rd_r <= lwc_mem[rt_raddr];
      use_rd_r <= use_mem[rt_raddr];
      ref_rd_r <= ref_mem[rt_raddr];
    end
  end

  always_comb begin
    rt_we     = 1'b0;
    rt_waddr  = RAW'(item_r.reg_id);
    lwc_wdata = lwc_rd_r;
    use_wdata = use_rd_r;
    ref_wdata = 1'b1;
    if (cmd.sweep && cmd.sweep_regs) begin
      rt_we     = sw_cnt_r < SW'(NUM_REGS);
      rt_waddr  = sw_cnt_r[RAW-1:0];
      lwc_wdata = '0;
      use_wdata = '0;
      ref_wdata = 1'b0;
    end else if (cmd.look && reg_ok && is_rd) begin
      rt_we = 1'b1;
      if (use_rd_r != UAW'(USE_BINS - 1)) use_wdata = use_rd_r + UAW'(1);
    end else if (cmd.look && reg_ok && is_wr) begin
      rt_we     = 1'b1;
      lwc_wdata = now_c;
      use_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rt_we) begin
      lwc_mem[rt_waddr] <= lwc_wdata;
      use_mem[rt_waddr] <= use_wdata;
      ref_mem[rt_waddr] <= ref_wdata;
    end
  end

  // ---------------- bin lookup ----------------
  // age wraps modulo 2^COUNT_BITS, then saturates to the top bin
  assign age     = now_c - lwc_rd_r;
  assign age_bin = (age >= COUNT_BITS'(AGE_BINS - 1)) ? AAW'(AGE_BINS - 1) : age[AAW-1:0];
  assign opx     = OPW'(item_r.op_count);
  assign oper_bin = (opx >= OPW'(OPER_BINS - 1)) ? OAW'(OPER_BINS - 1) : opx[OAW-1:0];
  assign bix     = BIW'(item_r.bin_index);

  always_comb begin
    case (item_r.table_select)
      TBL_AGE:  rd_hit = bix < BIW'(AGE_BINS);
      TBL_USE:  rd_hit = bix < BIW'(USE_BINS);
      TBL_OPER: rd_hit = bix < BIW'(OPER_BINS);
      default:  rd_hit = 1'b0;
    endcase
  end

  assign age_raddr  = is_bin ? bix[AAW-1:0] : age_bin;
  assign usdg_raddr = is_bin ? bix[UAW-1:0] : use_rd_r;
  assign oper_raddr = is_bin ? bix[OAW-1:0] : oper_bin;

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      age_rd_r    <= age_mem[age_raddr];
      usdg_rd_r   <= usdg_mem[usdg_raddr];
      oper_rd_r   <= oper_mem[oper_raddr];
      age_addr_r  <= age_raddr;
      usdg_addr_r <= usdg_raddr;
      oper_addr_r <= oper_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bump_age_r  <= 1'b0;
      bump_use_r  <= 1'b0;
      bump_oper_r <= 1'b0;
      rd_hit_r    <= 1'b0;
    end else if (cmd.look) begin
      bump_age_r  <= is_rd && reg_ok;
      bump_use_r  <= is_wr && reg_ok && ref_rd_r;
      bump_oper_r <= is_ins;
      rd_hit_r    <= is_bin && rd_hit;
    end
  end

  // ---------------- histogram update / clear ----------------
  always_comb begin
    age_we     = cmd.upd && bump_age_r;
    usdg_we    = cmd.upd && bump_use_r;
    oper_we    = cmd.upd && bump_oper_r;
    age_waddr  = age_addr_r;
    usdg_waddr = usdg_addr_r;
    oper_waddr = oper_addr_r;
    age_wdata  = (age_rd_r == '1) ? age_rd_r : age_rd_r + COUNT_BITS'(1);
    usdg_wdata = (usdg_rd_r == '1) ? usdg_rd_r : usdg_rd_r + COUNT_BITS'(1);
    oper_wdata = (oper_rd_r == '1) ? oper_rd_r : oper_rd_r + COUNT_BITS'(1);
    if (cmd.sweep) begin
      age_we     = sw_cnt_r < SW'(AGE_BINS);
      usdg_we    = sw_cnt_r < SW'(USE_BINS);
      oper_we    = sw_cnt_r < SW'(OPER_BINS);
      age_waddr  = sw_cnt_r[AAW-1:0];
      usdg_waddr = sw_cnt_r[UAW-1:0];
      oper_waddr = sw_cnt_r[OAW-1:0];
      age_wdata  = '0;
      usdg_wdata = '0;
      oper_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (age_we) age_mem[age_waddr] <= age_wdata;
    if (usdg_we) usdg_mem[usdg_waddr] <= usdg_wdata;
    if (oper_we) oper_mem[oper_waddr] <= oper_wdata;
  end

  // ---------------- output register ----------------
  always_comb begin
    case (item_r.table_select)
      TBL_AGE:  rd_sel = age_rd_r;
      TBL_USE:  rd_sel = usdg_rd_r;
      TBL_OPER: rd_sel = oper_rd_r;
      default:  rd_sel = '0;
    endcase
  end

  assign out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item_r.bin_value <= rd_hit_r ? BIN_VALUE_W'(rd_sel) : '0;
      out_item_r.bin_echo  <= item_r.bin_index;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_item_r;

  assign sts.sweep_done  = sweep_last;
  assign sts.out_blocked = out_valid_r && out_stall;
  assign sts.item_bin_rd = is_bin;

endmodule

// ----- rtl/core/register_dependency_profiler_unit.sv -----
// Read, write, instruction-end and bin readout items: per-register table read on acceptance,
// then histogram read in ST_LOOK, then histogram write in ST_UPD; the next item is taken in
// ST_UPD unless a readout there waits on a blocked output register. A readout result is
// registered from ST_UPD; unknown kinds go back to ST_IDLE. A clear item holds the input while
// the histograms are zeroed. Reset: synchronous, active low; then a clearing pass zeroes every
// table while the input is stalled.
module register_dependency_profiler_unit
  import rdp_pkg::*;
#(
  parameter int NUM_REGS   = DEF_NUM_REGS,
  parameter int AGE_BINS   = DEF_AGE_BINS,
  parameter int USE_BINS   = DEF_USE_BINS,
  parameter int OPER_BINS  = DEF_OPER_BINS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_payload,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_payload
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  rdp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_payload.kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rdp_dp #(
    .NUM_REGS   (NUM_REGS),
    .AGE_BINS   (AGE_BINS),
    .USE_BINS   (USE_BINS),
    .OPER_BINS  (OPER_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_payload  (in_payload),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload)
  );

endmodule

// ----- rtl/core/rdp_chk.sv -----
`include "register_dependency_profiler_unit_assert.svh"

module rdp_chk
  import rdp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_payload,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_payload
);

  // a stalled result stays put
  `RDP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_payload))

  // a fresh result only ever follows an accepted readout transaction, by way of ST_LOOK, ST_UPD and the output register
  `RDP_ASSERT_IMPL(a_out_from_bin_rd, $rose(out_valid), $past(in_valid && !in_stall && in_payload.kind == KIND_BIN_RD, 3))

  // clearing pass right after reset
  `RDP_ASSERT_IMPL(a_init_busy, !$past(rst_n), in_stall)

  // a clear transaction busies the input while the histograms are zeroed
  `RDP_ASSERT_NEXT(a_clear_busy, in_valid && !in_stall && in_payload.kind == KIND_CLEAR, in_stall)

endmodule

bind register_dependency_profiler_unit rdp_chk u_rdp_chk (.*);

// ----- bench/rdp_profile_mirror_pkg.sv -----
`timescale 1ns / 1ps
package rdp_profile_mirror_pkg;
  import rdp_pkg::*;

  localparam int NREG = DEF_NUM_REGS;
  localparam int AGEB = DEF_AGE_BINS;
  localparam int USEB = DEF_USE_BINS;
  localparam int OPB  = DEF_OPER_BINS;

  class profile_mirror;
    bit [INS_COUNT_W-1:0] last_write [NREG];
    int unsigned          use_count  [NREG];
    bit                   referenced [NREG];
    bit [BIN_VALUE_W-1:0] age_bins   [AGEB];
    bit [BIN_VALUE_W-1:0] use_bins   [USEB];
    bit [BIN_VALUE_W-1:0] oper_bins  [OPB];
    out_item_t            expected_bins [$];
    int unsigned mismatches;
    int unsigned n_rd, n_wr, n_end, n_bin, n_clr, n_skip;

    // bins stick at all ones
    function bit [BIN_VALUE_W-1:0] sat_inc(bit [BIN_VALUE_W-1:0] v);
      return (&v) ? v : v + 1'b1;
    endfunction

    function void absorb(in_item_t t);
      bit [INS_COUNT_W-1:0] age;
      int unsigned slot;
      out_item_t res;
      case (t.kind)
        KIND_REG_RD: begin
          n_rd++;
          if (int'(t.reg_id) < NREG) begin
            // modulo difference covers a count below the last write
            age = t.ins_count - last_write[t.reg_id];
            slot = (age >= AGEB) ? AGEB - 1 : int'(age);
            age_bins[slot] = sat_inc(age_bins[slot]);
            if (use_count[t.reg_id] < USEB - 1) use_count[t.reg_id]++;
            referenced[t.reg_id] = 1'b1;
          end
        end
        KIND_REG_WR: begin
          n_wr++;
          if (int'(t.reg_id) < NREG) begin
            if (referenced[t.reg_id]) begin
              slot = (use_count[t.reg_id] >= USEB) ? USEB - 1 : use_count[t.reg_id];
              use_bins[slot] = sat_inc(use_bins[slot]);
            end
            last_write[t.reg_id] = t.ins_count;
            use_count[t.reg_id]  = 0;
            referenced[t.reg_id] = 1'b1;
          end
        end
        KIND_INS_END: begin
          n_end++;
          slot = t.op_count;
          if (slot >= OPB) slot = OPB - 1;
          oper_bins[slot] = sat_inc(oper_bins[slot]);
        end
        KIND_BIN_RD: begin
          n_bin++;
          res.bin_echo  = t.bin_index;
          res.bin_value = '0;
          case (t.table_select)
            TBL_AGE:  if (t.bin_index < AGEB) res.bin_value = age_bins[t.bin_index];
            TBL_USE:  if (t.bin_index < USEB) res.bin_value = use_bins[t.bin_index];
            TBL_OPER: if (t.bin_index < OPB) res.bin_value = oper_bins[t.bin_index];
            default:  res.bin_value = '0;
          endcase
          expected_bins.push_back(res);
        end
        KIND_CLEAR: begin
          n_clr++;
          age_bins  = '{default: '0};
          use_bins  = '{default: '0};
          oper_bins = '{default: '0};
        end
        default: n_skip++;
      endcase
    endfunction

    function void compare(out_item_t got);
      out_item_t want;
      if (expected_bins.size() == 0) begin
        $error("bin readout with none pending: bin_value %0d bin_echo %0d",
               got.bin_value, got.bin_echo);
        mismatches++;
        return;
      end
      want = expected_bins.pop_front();
      if (got.bin_value !== want.bin_value) begin
        $error("bin_value mismatch: expected %0d actual %0d", want.bin_value, got.bin_value);
        mismatches++;
      end
      if (got.bin_echo !== want.bin_echo) begin
        $error("bin_echo mismatch: expected %0d actual %0d", want.bin_echo, got.bin_echo);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_bins.size();
    endfunction
  endclass

endpackage

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import rdp_pkg::*;
  import rdp_profile_mirror_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 200;

  localparam logic [KIND_W-1:0]      KIND_UNUSED_LO = 3'd5;
  localparam logic [KIND_W-1:0]      KIND_UNUSED_HI = 3'd7;
  localparam logic [TABLE_SEL_W-1:0] TBL_NONE       = 2'd3;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_payload;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_payload;

  profile_mirror mirror;
  bit               hold_req;
  bit               eager;
  int               tx_left;
  bit               tx_no_gap;
  bit [INS_COUNT_W-1:0] now_count;
  int unsigned      idle_cycles;

  register_dependency_profiler_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_payload(out_payload)
  );

  always #1 clk = ~clk;

  // cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic in_item_t mk(logic [KIND_W-1:0] k, logic [REG_ID_W-1:0] r,
                                  logic [INS_COUNT_W-1:0] ic, logic [OP_COUNT_W-1:0] op,
                                  logic [TABLE_SEL_W-1:0] tbl, logic [BIN_IDX_W-1:0] idx);
    in_item_t it;
    it.kind         = k;
    it.reg_id       = r;
    it.ins_count    = ic;
    it.op_count     = op;
    it.table_select = tbl;
    it.bin_index    = idx;
    return it;
  endfunction

  // mostly a slowly advancing count on a small register pool, plus noise
  function automatic in_item_t rand_item();
    in_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 199) == 0) now_count = {16'($urandom()), 32'($urandom())};
    now_count       = now_count + 48'($urandom_range(0, 3));
    it.ins_count    = ($urandom_range(0, 9) == 0) ? {16'($urandom()), 32'($urandom())}
                                                  : now_count;
    it.reg_id       = ($urandom_range(0, 6) == 0) ? 9'($urandom()) : 9'($urandom_range(0, 15));
    it.op_count     = 4'($urandom());
    it.table_select = 2'($urandom());
    it.bin_index    = $urandom_range(0, 1) ? 7'($urandom()) : 7'($urandom_range(0, 15));
    if (pick < 30) it.kind = KIND_REG_RD;
    else if (pick < 50) it.kind = KIND_REG_WR;
    else if (pick < 60) it.kind = KIND_INS_END;
    else if (pick < 90) it.kind = KIND_BIN_RD;
    else if (pick < 93) it.kind = KIND_CLEAR;
    else it.kind = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
    return it;
  endfunction

  task automatic offer(in_item_t it);
    int gap;
    if (tx_left == 0) begin
      tx_left   = $urandom_range(10, 40);
      tx_no_gap = ($urandom_range(0, 2) == 0);
    end
    tx_left--;
    gap = (tx_no_gap || eager) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_payload <= it;
    do @(posedge clk); while (in_stall);
    mirror.absorb(it);
  endtask

  // result side
  initial begin
    int hold;
    int rx_left;
    bit rx_no_stall;
    rx_left     = 0;
    rx_no_stall = 1'b0;
    out_stall   = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_left == 0) begin
        rx_left     = $urandom_range(10, 40);
        rx_no_stall = ($urandom_range(0, 2) == 0);
      end
      rx_left--;
      hold = rx_no_stall ? 0 : $urandom_range(0, 5);
      if (hold_req) begin
        hold_req = 1'b0;
        hold     = HOLD_CYCLES;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      mirror.compare(out_payload);
    end
  end

  initial begin
    int hot;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_payload = '0;
    mirror     = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    offer(mk(KIND_BIN_RD, 0, 0, 0, TBL_AGE, 0));
    offer(mk(KIND_REG_WR, 0, 10, 0, 0, 0));
    offer(mk(KIND_REG_RD, 0, 10, 0, 0, 0));
    offer(mk(KIND_REG_RD, 0, 13, 0, 0, 0));
    // count below the last write wraps to a huge age
    offer(mk(KIND_REG_RD, 0, 1, 0, 0, 0));
    offer(mk(KIND_REG_RD, 511, '1, 4'hf, TBL_NONE, 7'h7f));
    offer(mk(KIND_REG_WR, 511, '1, 0, 0, 0));
    offer(mk(KIND_REG_RD, 511, 5, 0, 0, 0));
    offer(mk(KIND_REG_WR, 0, 20, 0, 0, 0));
    offer(mk(KIND_REG_WR, 0, 21, 0, 0, 0));
    offer(mk(KIND_INS_END, 0, 0, 0, 0, 0));
    offer(mk(KIND_INS_END, 0, 0, 4'hf, 0, 0));
    offer(mk(KIND_UNUSED_LO, 3, 7, 2, TBL_AGE, 0));
    offer(mk(KIND_UNUSED_HI, '1, '1, '1, '1, '1));
    offer(mk(KIND_BIN_RD, 0, 0, 0, TBL_AGE, 0));
    offer(mk(KIND_BIN_RD, 0, 0, 0, TBL_AGE, 127));
    offer(mk(KIND_BIN_RD, 0, 0, 0, TBL_AGE, 6));
    offer(mk(KIND_BIN_RD, 0, 0, 0, TBL_USE, 3));
    offer(mk(KIND_BIN_RD, 0, 0, 0, TBL_USE, 0));
    offer(mk(KIND_BIN_RD, 0, 0, 0, TBL_OPER, 15));
    offer(mk(KIND_BIN_RD, 0, 0, 0, TBL_OPER, 16));
    offer(mk(KIND_BIN_RD, 0, 0, 0, TBL_NONE, 127));
    offer(mk(KIND_CLEAR, 0, 0, 0, 0, 0));
    offer(mk(KIND_BIN_RD, 0, 0, 0, TBL_AGE, 127));
    offer(mk(KIND_BIN_RD, 0, 0, 0, TBL_USE, 1));

    repeat (260) offer(rand_item());

    // one register read often enough to saturate its use counter
    hot = $urandom_range(0, 511);
    repeat (135) begin
      now_count = now_count + 1;
      offer(mk(KIND_REG_RD, hot, now_count, 0, 0, 0));
    end
    offer(mk(KIND_REG_WR, hot, now_count, 0, 0, 0));
    offer(mk(KIND_BIN_RD, 0, 0, 0, TBL_USE, 127));
    offer(mk(KIND_BIN_RD, 0, 0, 0, TBL_USE, 126));

    // back-to-back readouts against a long output hold-off
    eager    = 1'b1;
    hold_req = 1'b1;
    repeat (40) offer(mk(KIND_BIN_RD, 0, 0, 0, 2'($urandom()), 7'($urandom_range(0, 20))));
    eager = 1'b0;

    repeat (330) offer(rand_item());
    in_valid <= 1'b0;

    while (mirror.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d register reads, %0d writes, %0d instruction ends, %0d clears",
             mirror.n_rd, mirror.n_wr, mirror.n_end, mirror.n_clr);
    $display("%0d bin readouts checked, %0d ignored kinds, %0d mismatches",
             mirror.n_bin, mirror.n_skip, mirror.mismatches);
    if (mirror.mismatches == 0 && mirror.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
